@@ src/hkdi_pkg.sv @@
// ----------------------------------------------------------------------------
// hkdi_pkg
// Shared types and constants for the hashed key to dense index upsert block.
// ----------------------------------------------------------------------------
package hkdi_pkg;

	localparam int KEY_W = 32;
	localparam int IDX_W = 8;
	localparam int CAP_W = 9;

	// Capacity limits
	localparam logic [CAP_W-1:0] CAP_MAX   = 9'd256;
	localparam logic [CAP_W-1:0] SMALL_CAP = 9'd8;

	// MurmurHash3 x86_32 constants (one 4-byte block, seed 0)
	localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2  = 32'h1b873593;
	localparam logic [31:0] MM_FA  = 32'h85ebca6b;
	localparam logic [31:0] MM_FB  = 32'hc2b2ae35;
	localparam logic [31:0] MM_ADD = 32'he6546b64;
	localparam logic [31:0] MM_LEN = 32'd4;

	// Remainder unit: bits retired per cycle and cycles per operation
	localparam int DIV_STEP  = 4;
	localparam int DIV_ITERS = KEY_W / DIV_STEP;
	localparam int DIV_CNT_W = $clog2(DIV_ITERS);

	// Status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
	} slot_entry_t;

endpackage

@@ src/hkdi_ram.sv @@
// ----------------------------------------------------------------------------
// hkdi_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hkdi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/hkdi_hash.sv @@
// ----------------------------------------------------------------------------
// hkdi_hash
// Pipelined MurmurHash3 of one 32-bit key, seed 0; five register stages.
// ----------------------------------------------------------------------------
module hkdi_hash
	import hkdi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [KEY_W-1:0] key,
	output logic             out_valid,
	output logic [31:0]      hash
);

	logic [4:0]  vld_q;
	logic [31:0] k_s1, k_s2, h_s3, h_s4, h_s5;
	logic [31:0] mix3, mix4, mix5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], in_valid};
		end
	end

	assign mix3 = {k_s2[18:0], k_s2[31:19]};        // rotl 13
	assign mix4 = (h_s3 ^ MM_LEN) ^ ((h_s3 ^ MM_LEN) >> 16);
	assign mix5 = h_s4 ^ (h_s4 >> 13);

	always_ff @(posedge clk) begin
		k_s1 <= key * MM_C1;
		k_s2 <= {k_s1[16:0], k_s1[31:17]} * MM_C2;   // rotl 15
		h_s3 <= (mix3 * 32'd5) + MM_ADD;
		h_s4 <= mix4 * MM_FA;
		h_s5 <= mix5 * MM_FB;
	end

	assign out_valid = vld_q[4];
	assign hash      = h_s5 ^ (h_s5 >> 16);

endmodule

@@ src/hkdi_div.sv @@
// ----------------------------------------------------------------------------
// hkdi_div
// Iterative remainder of a 32-bit value by a 9-bit divisor, four bits a cycle.
// ----------------------------------------------------------------------------
module hkdi_div
	import hkdi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [CAP_W-1:0] divisor,
	output logic             done,
	output logic [CAP_W-1:0] remainder
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]     quo_q;
	logic [CAP_W-1:0]     rem_q;
	logic [CAP_W-1:0]     div_q;
	logic [KEY_W-1:0]     quo_nxt;
	logic [CAP_W-1:0]     rem_nxt;

	// restoring steps; remainder stays below divisor <= 256, so 9 bits hold it
	always_comb begin
		quo_nxt = quo_q;
		rem_nxt = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			rem_nxt = {rem_nxt[CAP_W-2:0], quo_nxt[KEY_W-1]};
			quo_nxt = {quo_nxt[KEY_W-2:0], 1'b0};
			if (rem_nxt >= div_q) begin
				rem_nxt = rem_nxt - div_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ src/hashed_key_to_dense_index_upsert.sv @@
// ----------------------------------------------------------------------------
// hashed_key_to_dense_index_upsert
// Find-or-insert of 32-bit keys in a linear-probing table, returning a dense
// insertion-order index per key.
// ----------------------------------------------------------------------------
// Flow: a zero-capacity request is answered from idle with an overflow result.
//   Capacity <= 8: remainder of the raw key, then a RAM read and a compare per
//   probed slot. Larger capacity first runs the key through the 5 hash stages.
// Throughput: one request at a time; busy stays high from accept until the
//   result strobe, and the next request can be taken at the edge that ends it;
//   a zero-capacity request never raises busy.
// Reset: used marks and key count clear at once; capacity resets to 256
//   (capped at the table depth). Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module hashed_key_to_dense_index_upsert
	import hkdi_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             capacity_we,
	input  logic [CAP_W-1:0] capacity,
	// request
	input  logic             start,
	input  logic [KEY_W-1:0] symbol_key,
	output logic             busy,
	// result
	output logic             done,
	output logic [IDX_W-1:0] dense_index,
	output logic             was_present,
	output logic             status
);

	// Only min(TABLE_DEPTH, 256) slots can ever be addressed.
	localparam int SLOTS = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(SLOTS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_HASH = 5'b00010,
		S_DIV  = 5'b00100,
		S_RD   = 5'b01000,
		S_CMP  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [CAP_W-1:0] cap_q;          // effective capacity
	logic [CAP_W-1:0] count_q;        // running dense index
	logic [SLOTS-1:0] used_q;         // per-slot used marks
	logic [KEY_W-1:0] key_q;
	logic [AW-1:0]    pos_q;          // current probe slot
	logic [CAP_W-1:0] probes_q;       // slots probed before the current one

	logic             done_q;
	logic [IDX_W-1:0] index_q;
	logic             present_q;
	logic             status_q;

	logic             accept;
	logic [CAP_W-1:0] cap_wr;
	logic             hash_valid;
	logic [31:0]      hash_val;
	logic             div_start;
	logic [KEY_W-1:0] div_arg;
	logic             div_done;
	logic [CAP_W-1:0] div_rem;
	logic             ram_we;
	slot_entry_t      ram_wdata;
	slot_entry_t      ram_rdata;
	logic [CAP_W-1:0] pos_inc;
	logic             slot_used;
	logic             last_probe;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Saturate the written capacity to 256 and to the table size.
	always_comb begin
		cap_wr = (capacity > CAP_MAX) ? CAP_MAX : capacity;
		if (cap_wr > CAP_LIMIT) begin
			cap_wr = CAP_LIMIT;
		end
	end

	// ---------------- home slot: hash then remainder by capacity -------------
	hkdi_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && (cap_q > SMALL_CAP)),
		.key       (symbol_key),
		.out_valid (hash_valid),
		.hash      (hash_val)
	);

	// Small tables take the raw key; larger ones wait for the hash.
	assign div_start = (accept && (cap_q != '0) && (cap_q <= SMALL_CAP)) ||
	                   ((state_q == S_HASH) && hash_valid);
	assign div_arg   = (state_q == S_HASH) ? hash_val : symbol_key;

	hkdi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_arg),
		.divisor   (cap_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// ---------------- slot store: key and dense index per slot --------------
	assign ram_we          = (state_q == S_CMP) && !slot_used;
	assign ram_wdata.key   = key_q;
	assign ram_wdata.idx   = count_q[IDX_W-1:0];

	hkdi_ram #(
		.WIDTH ($bits(slot_entry_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (ram_wdata),
		.re    (state_q == S_RD),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// Probe bookkeeping. Used marks are flops, so no RAM clear pass is needed;
	// an unused slot is never compared, so stale RAM contents do not matter.
	assign slot_used  = used_q[pos_q];
	assign pos_inc    = CAP_W'(pos_q) + CAP_W'(1);
	assign last_probe = ((probes_q + CAP_W'(1)) == cap_q);

	// ---------------- sequencer ----------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= CAP_LIMIT;
			count_q  <= '0;
			used_q   <= '0;
			done_q   <= 1'b0;
			probes_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (capacity_we) begin
				cap_q   <= cap_wr;
				count_q <= '0;
				used_q  <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cap_q == '0) begin
							done_q <= 1'b1;           // overflow, state untouched
						end else if (cap_q <= SMALL_CAP) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_valid) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						probes_q <= '0;
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!slot_used) begin
						used_q[pos_q] <= 1'b1;
						count_q       <= count_q + CAP_W'(1);
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else if ((ram_rdata.key == key_q) || last_probe) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						probes_q <= probes_q + CAP_W'(1);
						state_q  <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= symbol_key;
		end
		if ((state_q == S_DIV) && div_done) begin
			pos_q <= div_rem[AW-1:0];
		end else if ((state_q == S_CMP) && slot_used) begin
			pos_q <= (pos_inc == cap_q) ? '0 : pos_inc[AW-1:0];
		end

		if (accept) begin
			index_q   <= '0;
			present_q <= 1'b0;
			status_q  <= STATUS_OVERFLOW;
		end else if (state_q == S_CMP) begin
			if (!slot_used) begin
				index_q   <= count_q[IDX_W-1:0];
				present_q <= 1'b0;
				status_q  <= STATUS_OK;
			end else if (ram_rdata.key == key_q) begin
				index_q   <= ram_rdata.idx;
				present_q <= 1'b1;
				status_q  <= STATUS_OK;
			end else begin
				index_q   <= '0;
				present_q <= 1'b0;
				status_q  <= STATUS_OVERFLOW;
			end
		end
	end

	assign done        = done_q;
	assign dense_index = index_q;
	assign was_present = present_q;
	assign status      = status_q;

	// ---------------- assertions ---------------------------------------------
	// A result only follows a compare or a zero-capacity request.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_CMP) ||
		         (($past(state_q) == S_IDLE) && $past(start) && ($past(cap_q) == '0)))
		else $error("result strobe without a finished probe");

	// Probe position lies inside the configured capacity at each RAM read.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (CAP_W'(pos_q) < cap_q))
		else $error("probe slot beyond capacity");

	// Never more keys than slots.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("key count exceeds capacity");

	// Remainder unit finishes only while the sequencer waits for it.
	a_div_sync: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("remainder done outside divide state");

	// Probe count never reaches capacity while probing.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (probes_q < cap_q))
		else $error("probe count overran capacity");

endmodule
